>>> src/ssdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdd_pkg
// Shared types, codes and the segment table of the serial seven-segment
// display driver.
// ----------------------------------------------------------------------------
package ssdd_pkg;

  localparam int NUM_POS     = 4;
  localparam int FRAME_BITS  = 16;

  localparam logic [7:0]  SEG_BLANK  = 8'hFF;
  localparam logic [7:0]  SEG_ZERO   = 8'hC0;
  localparam logic [13:0] MAX_NUMBER = 14'd9999;

  typedef enum logic [2:0] {
    OP_WRITE_NUMBER = 3'd0,
    OP_WRITE_DIGIT  = 3'd1,
    OP_CLEAR        = 3'd2,
    OP_SHOW_ZEROS   = 3'd3,
    OP_HIDE_ZEROS   = 3'd4,
    OP_REFRESH      = 3'd5
  } op_t;

  // decoded command kinds handed from the front to the back
  typedef enum logic [2:0] {
    K_WRITE_ALL = 3'd0,
    K_WRITE_ONE = 3'd1,
    K_SHOW      = 3'd2,
    K_HIDE      = 3'd3,
    K_REFRESH   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [13:0] value_to_show;
    logic [3:0]  digit_value;
    logic [1:0]  digit_position;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_pulse;
    logic last;
  } out_item_t;

  // write one uses codes[0] at pos
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [1:0]                pos;
    logic [NUM_POS-1:0][7:0]   codes;
  } cmd_entry_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // k times the decimal place weight of a conversion step
  function automatic logic [13:0] place_mult(input logic [1:0] step, input int k);
    logic [13:0] m;
    case (step)
      2'd0:    m = 14'(k * 1000);
      2'd1:    m = 14'(k * 100);
      default: m = 14'(k * 10);
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/ssdd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdd_front
// Takes commands, clamps and splits numbers into digits one place per cycle,
// encodes segments and issues decoded commands into the command queue.
// ----------------------------------------------------------------------------
module ssdd_front import ssdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   command,
  output logic       q_push,
  output cmd_entry_t q_entry,
  input  logic       q_full
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CONVERT = 3'b010,
    ST_ISSUE   = 3'b100
  } state_t;

  state_t                  state;
  state_t                  state_next;
  cmd_kind_t               kind;
  logic [1:0]              pos;
  logic [NUM_POS-1:0][7:0] codes;
  logic [13:0]             rem;
  logic [1:0]              step;

  logic        accept;
  logic [3:0]  digit;
  logic [13:0] sub;
  logic [13:0] rem_next;

  assign full   = (state != ST_IDLE);
  assign accept = push && !full;
  assign q_push = (state == ST_ISSUE) && !q_full;

  assign q_entry.kind  = kind;
  assign q_entry.pos   = pos;
  assign q_entry.codes = codes;

  // largest multiple of the current place weight that fits
  always_comb begin
    digit = 4'd0;
    sub   = 14'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= place_mult(step, k)) begin
        digit = 4'(k);
        sub   = place_mult(step, k);
      end
    end
    rem_next = rem - sub;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(command.operation))
            OP_WRITE_NUMBER: state_next = ST_CONVERT;
            OP_WRITE_DIGIT, OP_CLEAR, OP_SHOW_ZEROS, OP_HIDE_ZEROS, OP_REFRESH:
              state_next = ST_ISSUE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONVERT: begin
        if (step == 2'd2) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (!q_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      pos  <= command.digit_position;
      step <= 2'd0;
      rem  <= (command.value_to_show > MAX_NUMBER) ? MAX_NUMBER : command.value_to_show;
      unique case (op_t'(command.operation))
        OP_WRITE_NUMBER: kind <= K_WRITE_ALL;
        OP_WRITE_DIGIT: begin
          kind     <= K_WRITE_ONE;
          codes[0] <= seg_encode(command.digit_value);
        end
        OP_CLEAR: begin
          kind  <= K_WRITE_ALL;
          codes <= {NUM_POS{SEG_BLANK}};
        end
        OP_SHOW_ZEROS: kind <= K_SHOW;
        OP_HIDE_ZEROS: kind <= K_HIDE;
        OP_REFRESH:    kind <= K_REFRESH;
        default:       kind <= kind;
      endcase
    end else if (state == ST_CONVERT) begin
      codes[~step] <= seg_encode(digit);
      rem          <= rem_next;
      step         <= step + 2'd1;
      // units digit is what is left after the tens step
      if (step == 2'd2) codes[0] <= seg_encode(rem_next[3:0]);
    end
  end

endmodule
`default_nettype wire

>>> src/ssdd_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdd_cmd_fifo
// Short queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module ssdd_cmd_fifo import ssdd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_entry_t entry_in,
  output logic       full,
  input  logic       pop,
  output cmd_entry_t entry_out,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  cmd_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == DEPTH_CNT);
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign entry_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= entry_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/ssdd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdd_back
// Holds the digit codes, carries out queued commands and shifts refresh
// frames out one bit per cycle, while the result side keeps popping, through an output register.
// ----------------------------------------------------------------------------
module ssdd_back import ssdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_entry_t q_entry,
  output logic       q_pop,
  output out_item_t  result,
  output logic       empty,
  input  logic       pop
);

  localparam int CNT_W = $clog2(NUM_POS * FRAME_BITS);

  logic [NUM_POS-1:0][7:0] digits;
  logic [NUM_POS-1:0][7:0] digits_next;
  logic [CNT_W-1:0]        cnt;
  logic                    out_valid;
  out_item_t               out_data;

  logic                    slot_free;
  logic                    emit;
  logic [1:0]              bit_pos;
  logic [3:0]              bit_idx;
  logic [15:0]             frame;
  out_item_t               bit_item;

  assign empty     = !out_valid;
  assign result    = out_data;
  assign slot_free = !out_valid || pop;

  assign bit_pos = cnt[CNT_W-1 -: 2];
  assign bit_idx = cnt[3:0];
  assign frame   = {digits[bit_pos], 8'(8'd1 << bit_pos)};

  // msb first within each frame
  assign bit_item.serial_bit  = frame[~bit_idx];
  assign bit_item.latch_pulse = &bit_idx;
  assign bit_item.last        = &cnt;

  always_comb begin
    digits_next = digits;
    q_pop       = 1'b0;
    emit        = 1'b0;
    if (!q_empty) begin
      unique case (q_entry.kind)
        K_WRITE_ALL: begin
          digits_next = q_entry.codes;
          q_pop       = 1'b1;
        end
        K_WRITE_ONE: begin
          digits_next[q_entry.pos] = q_entry.codes[0];
          q_pop                    = 1'b1;
        end
        K_SHOW: begin
          // top down, stop at the first position that is not blank
          if (digits[3] == SEG_BLANK) begin
            digits_next[3] = SEG_ZERO;
            if (digits[2] == SEG_BLANK) begin
              digits_next[2] = SEG_ZERO;
              if (digits[1] == SEG_BLANK) digits_next[1] = SEG_ZERO;
            end
          end
          q_pop = 1'b1;
        end
        K_HIDE: begin
          if (digits[3] == SEG_ZERO) begin
            digits_next[3] = SEG_BLANK;
            if (digits[2] == SEG_ZERO) begin
              digits_next[2] = SEG_BLANK;
              if (digits[1] == SEG_ZERO) digits_next[1] = SEG_BLANK;
            end
          end
          q_pop = 1'b1;
        end
        K_REFRESH: begin
          if (slot_free) begin
            emit  = 1'b1;
            q_pop = &cnt;
          end
        end
        default: q_pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits    <= {NUM_POS{SEG_BLANK}};
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      digits <= digits_next;
      if (emit) cnt <= cnt + CNT_W'(1);
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= bit_item;
  end

endmodule
`default_nettype wire

>>> src/seven_segment_serial_display_driver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_top
// Four-digit seven-segment display driver with a serial frame output.
// ----------------------------------------------------------------------------
// A command goes from the front's issue state through the queue to the back;
//   write number first passes the converter, one decimal place per cycle.
// The front takes no new command until the last enters the queue; a refresh
//   holds the back for 64 bits, one per cycle while the result side pops
// reset: synchronous, clears the queue and output register, all digits blank
module seven_segment_serial_display_driver_top import ssdd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  command,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  cmd_entry_t q_wr_entry;
  cmd_entry_t q_rd_entry;

  ssdd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .command (command),
    .q_push  (q_push),
    .q_entry (q_wr_entry),
    .q_full  (q_full)
  );

  ssdd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .entry_out (q_rd_entry),
    .empty     (q_empty)
  );

  ssdd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (q_rd_entry),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire

>>> src/ssdd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdd_checker
// Port-level checks of the display driver, bound to the top level.
// ----------------------------------------------------------------------------
module ssdd_checker import ssdd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  command,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("command side not ready after reset");

  // the front reports full once it has taken a valid command
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (push && !full && command.operation <= OP_REFRESH) |=> full)
    else $error("front ready right after a command transfer");

  // the end of a refresh run is always the end of a frame
  a_last_is_latch: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last) |-> result.latch_pulse)
    else $error("last bit without latch pulse");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

endmodule

bind seven_segment_serial_display_driver_top ssdd_checker u_checker (.*);
`default_nettype wire

>>> dv/seven_segment_serial_display_driver_checker.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_checker
// Watches both queue sides of the display driver, keeps its own copy of the
// four digit codes, turns every refresh into the 64 serial bits it must
// produce, and compares them in order with what the block pops out.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver_checker import ssdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  command,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result,
  output int        errors,
  output int        outstanding,
  output int        commands,
  output int        refreshes,
  output int        bits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic [7:0] shown_codes [NUM_POS];
  out_item_t  frame_bits [$];

  initial begin
    errors       = 0;
    outstanding  = 0;
    commands     = 0;
    refreshes    = 0;
    bits_checked = 0;
  end

  function automatic logic [7:0] segments_of(input logic [3:0] d);
    if (d > 4'd9) begin
      return SEG_BLANK;
    end
    return DIGIT_SEGMENTS[d];
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic update_display(input in_item_t c);
    logic [13:0] v;
    logic [15:0] frame;
    out_item_t   b;
    int          p;
    case (c.operation)
      OP_WRITE_NUMBER: begin
        v = (c.value_to_show > MAX_NUMBER) ? MAX_NUMBER : c.value_to_show;
        shown_codes[3] = segments_of(4'(v / 1000));
        shown_codes[2] = segments_of(4'((v / 100) % 10));
        shown_codes[1] = segments_of(4'((v / 10) % 10));
        shown_codes[0] = segments_of(4'(v % 10));
      end
      OP_WRITE_DIGIT: begin
        shown_codes[c.digit_position] = segments_of(c.digit_value);
      end
      OP_CLEAR: begin
        for (p = 0; p < NUM_POS; p++) shown_codes[p] = SEG_BLANK;
      end
      OP_SHOW_ZEROS: begin
        // walk down from the top digit, stop at the first non-blank one
        for (p = NUM_POS - 1; p >= 1; p--) begin
          if (shown_codes[p] != SEG_BLANK) break;
          shown_codes[p] = SEG_ZERO;
        end
      end
      OP_HIDE_ZEROS: begin
        for (p = NUM_POS - 1; p >= 1; p--) begin
          if (shown_codes[p] != SEG_ZERO) break;
          shown_codes[p] = SEG_BLANK;
        end
      end
      OP_REFRESH: begin
        refreshes++;
        for (p = 0; p < NUM_POS; p++) begin
          frame = {shown_codes[p], 8'(1 << p)};
          for (int i = 0; i < FRAME_BITS; i++) begin
            b.serial_bit  = frame[FRAME_BITS-1-i];
            b.latch_pulse = (i == FRAME_BITS - 1);
            b.last        = (p == NUM_POS - 1) && (i == FRAME_BITS - 1);
            frame_bits.push_back(b);
          end
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
  endtask

  task automatic check_bit(input out_item_t got);
    out_item_t want;
    if (frame_bits.size() == 0) begin
      report_mismatch($sformatf("bit %b popped with nothing pending", got));
      return;
    end
    want = frame_bits.pop_front();
    bits_checked++;
    if (got.serial_bit !== want.serial_bit)
      report_mismatch($sformatf("bit %0d serial_bit %b, want %b",
                                bits_checked, got.serial_bit, want.serial_bit));
    if (got.latch_pulse !== want.latch_pulse)
      report_mismatch($sformatf("bit %0d latch_pulse %b, want %b",
                                bits_checked, got.latch_pulse, want.latch_pulse));
    if (got.last !== want.last)
      report_mismatch($sformatf("bit %0d last %b, want %b",
                                bits_checked, got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_POS; p++) shown_codes[p] = SEG_BLANK;
      frame_bits.delete();
    end else begin
      // a command taken at this edge cannot produce a bit at the same edge
      if (pop && !empty) check_bit(result);
      if (push && !full) begin
        commands++;
        update_display(command);
      end
    end
    outstanding = frame_bits.size();
  end

endmodule

>>> dv/tb_seven_segment_serial_display_driver_top.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_serial_display_driver_top
// Drives directed and random display commands into the driver with random
// gaps and output stalls, a long output hold-off and drain pauses; the
// checker beside the block predicts and compares every serial bit.
// ----------------------------------------------------------------------------
module tb_seven_segment_serial_display_driver_top;
  import ssdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS   = 225;
  localparam int          CYCLE_LIMIT    = 2_000_000;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES   = 80;
  localparam logic [2:0]  OP_SPARE_6     = 3'd6;
  localparam logic [2:0]  OP_SPARE_7     = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  command = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  int errors, outstanding, commands, refreshes, bits_checked;
  int cycle_count = 0;
  bit hold_request = 1'b0;

  seven_segment_serial_display_driver_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .command(command),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  seven_segment_serial_display_driver_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .commands    (commands),
    .refreshes   (refreshes),
    .bits_checked(bits_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("seven_segment_serial_display_driver_top verification failed");
      $finish;
    end
  end

  function automatic in_item_t display_cmd(input logic [2:0] op, input int val,
                                           input int dval, input int dpos);
    in_item_t c;
    c.operation      = op;
    c.value_to_show  = 14'(val);
    c.digit_value    = 4'(dval);
    c.digit_position = 2'(dpos);
    return c;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    int       r;
    c.value_to_show  = ($urandom_range(0, 2) == 0) ? 14'($urandom_range(0, 99))
                                                   : 14'($urandom);
    c.digit_value    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(0, 9));
    c.digit_position = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 18)      c.operation = OP_WRITE_NUMBER;
    else if (r < 38) c.operation = OP_WRITE_DIGIT;
    else if (r < 45) c.operation = OP_CLEAR;
    else if (r < 60) c.operation = OP_SHOW_ZEROS;
    else if (r < 75) c.operation = OP_HIDE_ZEROS;
    else if (r < 96) c.operation = OP_REFRESH;
    else             c.operation = r[0] ? OP_SPARE_7 : OP_SPARE_6;
    return c;
  endfunction

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_command(input in_item_t c, input int gap);
    push    <= 1'b1;
    command <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int sink_cycles;
    int r;
    bit hold_taken;
    stall_left  = 0;
    hold_left   = 0;
    sink_cycles = 0;
    hold_taken  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      sink_cycles++;
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if ((sink_cycles / 256) % 4 == 1) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          pop <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
          pop <= 1'b0;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_item_t directed [$];
    in_item_t c;
    int       sent;
    int       gap;
    bit       useful;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed = '{
      display_cmd(OP_REFRESH,      0,     0,  0),   // blank after reset
      display_cmd(OP_WRITE_NUMBER, 0,     0,  0),
      display_cmd(OP_REFRESH,      0,     0,  0),
      display_cmd(OP_WRITE_NUMBER, 9999,  0,  0),
      display_cmd(OP_WRITE_NUMBER, 10000, 0,  0),   // clamps
      display_cmd(OP_REFRESH,      16383, 15, 3),
      display_cmd(OP_WRITE_NUMBER, 16383, 15, 3),
      display_cmd(OP_HIDE_ZEROS,   0,     0,  0),   // nothing to hide
      display_cmd(OP_CLEAR,        16383, 15, 3),
      display_cmd(OP_SHOW_ZEROS,   0,     0,  0),   // units stays blank
      display_cmd(OP_REFRESH,      0,     0,  0),
      display_cmd(OP_HIDE_ZEROS,   0,     0,  0),
      display_cmd(OP_WRITE_DIGIT,  0,     7,  0),
      display_cmd(OP_WRITE_DIGIT,  0,     15, 3),   // above nine goes blank
      display_cmd(OP_WRITE_DIGIT,  0,     9,  2),
      display_cmd(OP_SHOW_ZEROS,   0,     0,  0),   // stops at position 2
      display_cmd(OP_REFRESH,      0,     0,  0),
      display_cmd(OP_WRITE_NUMBER, 5,     0,  0),
      display_cmd(OP_HIDE_ZEROS,   0,     0,  0),
      display_cmd(OP_SPARE_6,      16383, 15, 3),
      display_cmd(OP_SPARE_7,      16383, 15, 3),
      display_cmd(OP_WRITE_DIGIT,  0,     0,  1),
      display_cmd(OP_SHOW_ZEROS,   0,     0,  0),   // stops on the written zero
      display_cmd(OP_HIDE_ZEROS,   0,     0,  0),   // clears down to position 1
      display_cmd(OP_REFRESH,      0,     0,  0)
    };
    foreach (directed[i]) begin
      gap = idle_gap();
      if (i == directed.size() - 1 && gap == 0) gap = 1;
      send_command(directed[i], gap);
    end

    // sender waits for every bit, then the result side holds off
    wait_for_drain();
    repeat (8) @(negedge clk);
    hold_request = 1'b1;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c      = random_command();
      useful = (c.operation <= OP_REFRESH);
      gap    = (sent >= 60 && sent < 100) ? 0 : idle_gap();
      if (useful && (sent + 1 == RANDOM_ITEMS / 2 || sent + 1 == RANDOM_ITEMS)
          && gap == 0)
        gap = 1;
      send_command(c, gap);
      if (useful) begin
        sent++;
        if (sent == RANDOM_ITEMS / 2) begin
          wait_for_drain();
          repeat (8) @(negedge clk);
        end
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d refreshes, %0d serial bits compared",
             commands, refreshes, bits_checked);
    $display("with input gaps, output stalls, a %0d-cycle output hold-off and drains",
             RX_HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("seven_segment_serial_display_driver_top verification clean");
    end else begin
      $display("seven_segment_serial_display_driver_top verification failed");
    end
    $finish;
  end

endmodule
